// File: hdl/lz_stream_decompressor_macros.svh
// assertion helpers used by the checker file
`ifndef LZ_STREAM_DECOMPRESSOR_MACROS_SVH
`define LZ_STREAM_DECOMPRESSOR_MACROS_SVH

// checked only while out of reset
`define LZSD_CHECK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define LZSD_CHECK_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/lzsd_pkg.sv
package lzsd_pkg;

	localparam int HISTORY_DEPTH = 65536;
	localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
	localparam int FILL_W        = $clog2(HISTORY_DEPTH + 1);
	// widest fill count and copy offset, for compares
	localparam int CMP_W         = 17;
	localparam int SRC_W         = CMP_W + 1;
	localparam int OFF_W         = 16;
	localparam int LEN_W         = 7;
	localparam int REM_W         = 33;

	// element type in header bits 1..0
	localparam logic [1:0] ELEM_LIT   = 2'd0;
	localparam logic [1:0] ELEM_SHORT = 2'd1;
	localparam logic [1:0] ELEM_LONG  = 2'd2;
	localparam logic [1:0] ELEM_BAD   = 2'd3;

	// literal length codes from here on use extra length bytes
	localparam logic [5:0] LIT_EXT_MIN  = 6'd60;
	localparam logic [5:0] LIT_EXT_BIAS = 6'd59;

	typedef enum logic [1:0] {
		CMD_NONE = 2'd0,
		CMD_LIT  = 2'd1,
		CMD_ERR  = 2'd2,
		CMD_COPY = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		logic             frame_clr;
		cmd_kind_t        kind;
		logic [7:0]       data;
		logic [OFF_W-1:0] offset;
		logic [LEN_W-1:0] len;
	} lzsd_cmd_t;

endpackage

// File: hdl/lzsd_ram.sv
module lzsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/lzsd_parser.sv
module lzsd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        code_byte,
	input  logic              frame_start,
	output lzsd_pkg::lzsd_cmd_t cmd
);
	import lzsd_pkg::*;

	typedef enum logic [6:0] {
		PH_PREAMBLE = 7'b0000001,
		PH_HEADER   = 7'b0000010,
		PH_LITLEN   = 7'b0000100,
		PH_LITDATA  = 7'b0001000,
		PH_SHORTOFF = 7'b0010000,
		PH_LONGLO   = 7'b0100000,
		PH_LONGHI   = 7'b1000000
	} phase_t;

	phase_t           phase_q, phase_d, phase_cur;
	logic [7:0]       hdr_q, hdr_d;
	logic [REM_W-1:0] rem_q, rem_d, rem_or, rem_dec;
	logic [2:0]       left_q, left_d, total;
	logic [1:0]       idx;
	logic [7:0]       offlo_q, offlo_d;

	always_comb begin
		phase_cur = frame_start ? PH_PREAMBLE : phase_q;
		phase_d   = phase_cur;
		hdr_d     = hdr_q;
		rem_d     = rem_q;
		left_d    = left_q;
		offlo_d   = offlo_q;
		total     = 3'(hdr_q[7:2] - LIT_EXT_BIAS);
		idx       = 2'(total - left_q);
		rem_or    = rem_q | (REM_W'(code_byte) << {idx, 3'b000});
		rem_dec   = (rem_q != '0) ? rem_q - 1'b1 : rem_q;
		cmd.frame_clr = frame_start;
		cmd.kind      = CMD_NONE;
		cmd.data      = code_byte;
		cmd.offset    = '0;
		cmd.len       = '0;
		unique case (phase_cur)
			PH_PREAMBLE: begin
				if (!code_byte[7]) begin
					phase_d = PH_HEADER;
				end
			end
			PH_HEADER: begin
				hdr_d = code_byte;
				unique case (code_byte[1:0])
					ELEM_LIT: begin
						if (code_byte[7:2] < LIT_EXT_MIN) begin
							rem_d   = REM_W'(code_byte[7:2]) + 1'b1;
							phase_d = PH_LITDATA;
						end else begin
							rem_d   = '0;
							left_d  = 3'(code_byte[7:2] - LIT_EXT_BIAS);
							phase_d = PH_LITLEN;
						end
					end
					ELEM_SHORT: phase_d = PH_SHORTOFF;
					ELEM_LONG:  phase_d = PH_LONGLO;
					ELEM_BAD:   cmd.kind = CMD_ERR;
					default:    cmd.kind = CMD_ERR;
				endcase
			end
			PH_LITLEN: begin
				left_d = left_q - 1'b1;
				rem_d  = rem_or;
				if (left_d == '0) begin
					rem_d   = rem_or + 1'b1;
					phase_d = PH_LITDATA;
				end
			end
			PH_LITDATA: begin
				cmd.kind = CMD_LIT;
				rem_d    = rem_dec;
				if (rem_dec == '0) begin
					phase_d = PH_HEADER;
				end
			end
			PH_SHORTOFF: begin
				cmd.kind   = CMD_COPY;
				cmd.offset = OFF_W'({hdr_q[7:5], code_byte});
				cmd.len    = LEN_W'(hdr_q[4:2]) + LEN_W'(4);
				phase_d    = PH_HEADER;
			end
			PH_LONGLO: begin
				offlo_d = code_byte;
				phase_d = PH_LONGHI;
			end
			PH_LONGHI: begin
				cmd.kind   = CMD_COPY;
				cmd.offset = {code_byte, offlo_q};
				cmd.len    = LEN_W'(hdr_q[7:2]) + 1'b1;
				phase_d    = PH_HEADER;
			end
			default: phase_d = PH_HEADER;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PREAMBLE;
			hdr_q   <= '0;
			rem_q   <= '0;
			left_q  <= '0;
			offlo_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			hdr_q   <= hdr_d;
			rem_q   <= rem_d;
			left_q  <= left_d;
			offlo_q <= offlo_d;
		end
	end

endmodule

// File: hdl/lzsd_hist_engine.sv
module lzsd_hist_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  lzsd_pkg::lzsd_cmd_t cmd,
	input  logic                out_stall,
	output logic                busy,
	output logic                out_valid,
	output logic [7:0]          out_byte,
	output logic                last_of_run,
	output logic                format_error
);
	import lzsd_pkg::*;

	typedef enum logic [2:0] {
		ENG_IDLE = 3'b001,
		ENG_RD   = 3'b010,
		ENG_WR   = 3'b100
	} eng_state_t;

	eng_state_t        state_q, state_d;
	logic [HIST_AW-1:0] wp_q, wp_inc, ram_raddr;
	logic [FILL_W-1:0] filled_q, filled_inc;
	logic [OFF_W-1:0]  off_q;
	logic [LEN_W-1:0]  len_q;
	logic [SRC_W-1:0]  diff, src_wrap;
	logic              ov_q, ol_q, oe_q;
	logic [7:0]        ob_q, ram_wdata, ram_rdata;
	logic              out_free, off_bad, lit_wr, copy_wr, err_load, ram_we, ram_re, load;

	assign out_free = !ov_q || !out_stall;
	assign off_bad  = (cmd.offset == '0) || (CMP_W'(cmd.offset) > CMP_W'(filled_q));
	assign lit_wr   = cmd_valid && (cmd.kind == CMD_LIT);
	assign err_load = cmd_valid && ((cmd.kind == CMD_ERR) || ((cmd.kind == CMD_COPY) && off_bad));
	assign copy_wr  = (state_q == ENG_WR) && out_free;
	assign load     = lit_wr || err_load || copy_wr;

	// source address, wrapped back into the history ring
	assign diff      = SRC_W'(wp_q) - SRC_W'(off_q);
	assign src_wrap  = diff[SRC_W-1] ? diff + SRC_W'(HISTORY_DEPTH) : diff;
	assign ram_raddr = src_wrap[HIST_AW-1:0];

	assign ram_we    = lit_wr || copy_wr;
	assign ram_re    = (state_q == ENG_RD);
	assign ram_wdata = lit_wr ? cmd.data : ram_rdata;

	assign wp_inc     = (wp_q == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign filled_inc = (filled_q == FILL_W'(HISTORY_DEPTH)) ? filled_q : filled_q + 1'b1;

	lzsd_ram #(
		.WIDTH(8),
		.DEPTH(HISTORY_DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wp_q),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ENG_IDLE: begin
				if (cmd_valid && (cmd.kind == CMD_COPY) && !off_bad) begin
					state_d = ENG_RD;
				end
			end
			ENG_RD: state_d = ENG_WR;
			ENG_WR: begin
				if (out_free) begin
					state_d = (len_q == LEN_W'(1)) ? ENG_IDLE : ENG_RD;
				end
			end
			default: state_d = ENG_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ENG_IDLE;
			wp_q     <= '0;
			filled_q <= '0;
			ov_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd_valid && cmd.frame_clr) begin
				wp_q     <= '0;
				filled_q <= '0;
			end else if (ram_we) begin
				wp_q     <= wp_inc;
				filled_q <= filled_inc;
			end
			if (load) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && (cmd.kind == CMD_COPY)) begin
			off_q <= cmd.offset;
			len_q <= cmd.len;
		end else if (copy_wr) begin
			len_q <= len_q - 1'b1;
		end
		if (load) begin
			ob_q <= lit_wr ? cmd.data : (err_load ? 8'h00 : ram_rdata);
			ol_q <= (lit_wr || err_load) ? 1'b1 : (len_q == LEN_W'(1));
			oe_q <= err_load;
		end
	end

	assign busy         = (state_q != ENG_IDLE);
	assign out_valid    = ov_q;
	assign out_byte     = ob_q;
	assign last_of_run  = ol_q;
	assign format_error = oe_q;

endmodule

// File: hdl/lz_stream_decompressor.sv
// a literal byte is registered and shows on the output the cycle after its transaction
// copy: per byte, ENG_RD reads the history ram, ENG_WR writes it and loads the output
// throughput: one input byte per cycle while the output is free; copies hold input
// the history ram read-then-write per copied byte sets the copy rate
// reset: arst_n async low clears parse phase, fill count, write position and output valid
// history contents are not cleared, a frame only ever reads bytes it wrote
module lz_stream_decompressor (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] code_byte,
	input  logic       frame_start,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       last_of_run,
	output logic       format_error
);
	import lzsd_pkg::*;

	lzsd_cmd_t cmd;
	logic      eng_busy;
	logic      accept;

	// hold input while a copy runs or the output register cannot take a result
	assign in_stall = eng_busy || (out_valid && out_stall);
	assign accept   = in_valid && !in_stall;

	// byte parser: preamble, headers, length and offset bytes
	lzsd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.code_byte  (code_byte),
		.frame_start(frame_start),
		.cmd        (cmd)
	);

	// history ring, copy sequencer and output register
	lzsd_hist_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (accept),
		.cmd         (cmd),
		.out_stall   (out_stall),
		.busy        (eng_busy),
		.out_valid   (out_valid),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.format_error(format_error)
	);

endmodule

// File: hdl/lzsd_checker.sv
`include "lz_stream_decompressor_macros.svh"

module lzsd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] code_byte,
	input logic       frame_start,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       last_of_run,
	input logic       format_error
);

	// a held result keeps its contents
	`LZSD_CHECK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last_of_run) && $stable(format_error), "stalled result changed")

	// an error transaction is a lone zero byte that ends its run
	`LZSD_CHECK(a_err_shape, out_valid && format_error |-> out_byte == 8'h00 && last_of_run, "bad error result")

	// no input taken while a result waits
	`LZSD_CHECK(a_in_blocked, out_valid && out_stall |-> in_stall, "input taken over a held result")

	// a stalled input transaction stays put
	`LZSD_CHECK(a_in_hold, in_valid && in_stall |=> in_valid && $stable(code_byte) && $stable(frame_start), "stalled input changed")

	// nothing offered once a reset edge has been seen
	`LZSD_CHECK_RST(a_rst_quiet, !arst_n |=> !out_valid, "output valid in reset")

endmodule

bind lz_stream_decompressor lzsd_checker u_chk (.*);

// File: tb/lz_stream_decompressor_test.sv
module lz_stream_decompressor_test;
	timeunit 1ns;
	timeprecision 1ps;

	import lzsd_pkg::*;

	// stimulus sizing and time limits
	localparam int RANDOM_ITEMS     = 150;
	localparam int HOLD_OFF_CYCLES  = 300;
	// longest quiet stretch: the hold-off, or a 64 byte copy behind a
	// heavily stalling receiver, with plenty of margin
	localparam int WATCHDOG_LIMIT   = 4000;
	localparam int DRAIN_CYCLES     = 200;

	// parse phases of the decoder mirror kept here
	typedef enum logic [2:0] {
		DP_PREAMBLE,
		DP_HEADER,
		DP_LITLEN,
		DP_LITDATA,
		DP_SHORTOFF,
		DP_LONGLO,
		DP_LONGHI
	} dec_phase_t;

	// receiver stall patterns
	typedef enum logic [1:0] {
		RX_OPEN,
		RX_LIGHT,
		RX_HEAVY,
		RX_PERIODIC
	} rx_mode_t;

	// one decoded output byte as the block should present it
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       err;
	} dec_beat_t;

	logic       clk;
	logic       arst_n      = 1'b0;
	logic       in_valid    = 1'b0;
	logic       in_stall;
	logic [7:0] code_byte   = 8'h00;
	logic       frame_start = 1'b0;
	logic       out_valid;
	logic       out_stall   = 1'b0;
	logic [7:0] out_byte;
	logic       last_of_run;
	logic       format_error;

	lz_stream_decompressor DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.code_byte    (code_byte),
		.frame_start  (frame_start),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.last_of_run  (last_of_run),
		.format_error (format_error)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// decoder mirror state, advanced once per accepted input transaction
	logic [7:0]        hist_mem [HISTORY_DEPTH];
	logic [HIST_AW-1:0] hist_wr        = '0;
	logic [FILL_W-1:0] hist_fill       = '0;
	dec_phase_t        dec_phase       = DP_PREAMBLE;
	logic [7:0]        hdr_byte        = 8'h00;
	logic [REM_W-1:0]  lit_left        = '0;
	logic [2:0]        len_bytes_left  = '0;
	logic [7:0]        off_lo          = 8'h00;
	dec_beat_t         decoded_q [$];

	int unsigned fail_count   = 0;
	int unsigned bytes_sent   = 0;
	int unsigned quiet_cycles = 0;

	// stream fill as seen by the stimulus side, used to pick legal offsets
	int unsigned stream_fill = 0;
	int unsigned burst_left  = 0;

	// receiver side
	int unsigned hold_requests = 0;
	int unsigned hold_served   = 0;
	int unsigned hold_left     = 0;
	int unsigned mode_left     = 0;
	int unsigned stall_tick    = 0;
	rx_mode_t    rx_mode       = RX_OPEN;
	logic        stalling;

	// ---------------------------------------------------------------
	// decoder mirror
	// ---------------------------------------------------------------

	// append one expected result to the tail of the queue
	task automatic queue_beat(input logic [7:0] d, input logic l, input logic e);
		dec_beat_t beat;
		beat.data = d;
		beat.last = l;
		beat.err = e;
		decoded_q = {decoded_q, beat};
	endtask

	task automatic store_hist(input logic [7:0] b);
		hist_mem[hist_wr] = b;
		hist_wr = hist_wr + 1'b1;
		if (hist_fill < HISTORY_DEPTH)
			hist_fill = hist_fill + 1'b1;
	endtask

	// copy replays from history one byte at a time, so overlap just works
	task automatic copy_run(input int unsigned offset, input int unsigned len);
		logic [HIST_AW-1:0] src;
		logic [7:0]         d;
		dec_phase = DP_HEADER;
		if (offset == 0 || offset > hist_fill) begin
			queue_beat(8'h00, 1'b1, 1'b1);
		end else begin
			for (int i = 0; i < len; i++) begin
				src = hist_wr - HIST_AW'(offset);
				d = hist_mem[src];
				store_hist(d);
				queue_beat(d, (i == len - 1), 1'b0);
			end
		end
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic fs);
		logic [5:0]  n;
		int unsigned idx;
		// a frame start drops whatever element was in flight
		if (fs) begin
			hist_fill = '0;
			hist_wr = '0;
			dec_phase = DP_PREAMBLE;
		end
		n = b[7:2];
		case (dec_phase)
			DP_PREAMBLE: begin
				// base-128 length, value unused, ends on a byte with bit 7 clear
				if (!b[7])
					dec_phase = DP_HEADER;
			end
			DP_HEADER: begin
				hdr_byte = b;
				case (b[1:0])
					ELEM_LIT: begin
						if (n < LIT_EXT_MIN) begin
							lit_left = REM_W'(n) + 1'b1;
							dec_phase = DP_LITDATA;
						end else begin
							lit_left = '0;
							len_bytes_left = 3'(n - LIT_EXT_BIAS);
							dec_phase = DP_LITLEN;
						end
					end
					ELEM_SHORT: dec_phase = DP_SHORTOFF;
					ELEM_LONG:  dec_phase = DP_LONGLO;
					default: begin
						// illegal element type, parsing goes on with the next header
						queue_beat(8'h00, 1'b1, 1'b1);
					end
				endcase
			end
			DP_LITLEN: begin
				// little-endian length minus one
				idx = (int'(hdr_byte[7:2]) - int'(LIT_EXT_BIAS) - int'(len_bytes_left)) & 3;
				lit_left = lit_left | (REM_W'(b) << (8 * idx));
				len_bytes_left = len_bytes_left - 1'b1;
				if (len_bytes_left == 0) begin
					lit_left = lit_left + 1'b1;
					dec_phase = DP_LITDATA;
				end
			end
			DP_LITDATA: begin
				store_hist(b);
				queue_beat(b, 1'b1, 1'b0);
				if (lit_left != 0)
					lit_left = lit_left - 1'b1;
				if (lit_left == 0)
					dec_phase = DP_HEADER;
			end
			DP_SHORTOFF: begin
				copy_run(32'({hdr_byte[7:5], b}), int'(hdr_byte[4:2]) + 4);
			end
			DP_LONGLO: begin
				off_lo = b;
				dec_phase = DP_LONGHI;
			end
			DP_LONGHI: begin
				copy_run(32'({b, off_lo}), int'(hdr_byte[7:2]) + 1);
			end
			default: dec_phase = DP_HEADER;
		endcase
	endtask

	// ---------------------------------------------------------------
	// monitor: mirror on input transactions, compare on output ones
	// inputs were driven by nba, so everything here is the pre-edge value
	// ---------------------------------------------------------------

	always @(posedge clk) begin : monitor
		dec_beat_t want;
		if (arst_n && in_valid && !in_stall)
			decode_byte(code_byte, frame_start);
		if (arst_n && out_valid && !out_stall) begin
			if (decoded_q.size() == 0) begin
				fail_count++;
				$error("result with none pending: out_byte %0h last_of_run %0b format_error %0b",
					out_byte, last_of_run, format_error);
			end else begin
				want = decoded_q.pop_front();
				if (out_byte !== want.data) begin
					fail_count++;
					$error("out_byte: expected %0h, got %0h", want.data, out_byte);
				end
				if (last_of_run !== want.last) begin
					fail_count++;
					$error("last_of_run: expected %0b, got %0b", want.last, last_of_run);
				end
				if (format_error !== want.err) begin
					fail_count++;
					$error("format_error: expected %0b, got %0b", want.err, format_error);
				end
			end
		end
	end

	// watchdog on cycles where neither side completes a transaction
	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver: its own stall pattern, picked at random and switched when mode_left runs out,
	// plus a long hold-off on request to back the block up
	always @(posedge clk) begin : receiver
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = HOLD_OFF_CYCLES;
		end
		if (mode_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(16, 160);
		end else begin
			mode_left--;
		end
		stall_tick++;
		if (hold_left != 0) begin
			hold_left--;
			stalling = 1'b1;
		end else begin
			case (rx_mode)
				RX_OPEN:  stalling = 1'b0;
				RX_LIGHT: stalling = ($urandom_range(0, 7) == 0);
				RX_HEAVY: stalling = ($urandom_range(0, 3) != 0);
				default:  stalling = ((stall_tick % 7) < 3);
			endcase
		end
		out_stall <= stalling;
	end

	// ---------------------------------------------------------------
	// sender
	// ---------------------------------------------------------------

	// one input transaction; the sender runs in bursts with gaps between
	task automatic send_byte(input logic [7:0] b, input logic fs);
		int unsigned gap;
		in_valid <= 1'b1;
		code_byte <= b;
		frame_start <= fs;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		bytes_sent++;
		gap = 0;
		if (burst_left != 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 32);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		end
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic grow_fill(input int unsigned n);
		stream_fill = (stream_fill + n > HISTORY_DEPTH) ? HISTORY_DEPTH : stream_fill + n;
	endtask

	// new frame with a random preamble of one to three bytes
	task automatic put_frame_start();
		int unsigned n;
		logic [6:0]  v;
		n = $urandom_range(1, 3);
		for (int i = 0; i < n; i++) begin
			v = 7'($urandom_range(0, 127));
			send_byte({(i != n - 1), v}, (i == 0));
		end
		stream_fill = 0;
	endtask

	// code below 60 uses the length in the header, 60..63 adds length bytes
	task automatic put_literal(input int unsigned len, input int unsigned code);
		logic [31:0] lm1;
		logic [5:0]  c;
		lm1 = len - 1;
		c = 6'(code);
		if (code < LIT_EXT_MIN) begin
			send_byte({lm1[5:0], ELEM_LIT}, 1'b0);
		end else begin
			send_byte({c, ELEM_LIT}, 1'b0);
			for (int i = 0; i < code - LIT_EXT_BIAS; i++)
				send_byte(lm1[8 * i +: 8], 1'b0);
		end
		repeat (len) send_byte(8'($urandom_range(0, 255)), 1'b0);
		grow_fill(len);
	endtask

	task automatic put_short_copy(input int unsigned len, input int unsigned off);
		logic [10:0] o;
		logic [2:0]  l;
		o = 11'(off);
		l = 3'(len - 4);
		send_byte({o[10:8], l, ELEM_SHORT}, 1'b0);
		send_byte(o[7:0], 1'b0);
		if (off != 0 && off <= stream_fill)
			grow_fill(len);
	endtask

	task automatic put_long_copy(input int unsigned len, input int unsigned off);
		logic [15:0] o;
		logic [5:0]  l;
		o = 16'(off);
		l = 6'(len - 1);
		send_byte({l, ELEM_LONG}, 1'b0);
		send_byte(o[7:0], 1'b0);
		send_byte(o[15:8], 1'b0);
		if (off != 0 && off <= stream_fill)
			grow_fill(len);
	endtask

	task automatic put_bad_type(input logic [5:0] upper);
		send_byte({upper, ELEM_BAD}, 1'b0);
	endtask

	// legal distance, short ones favored to get overlapping copies
	function automatic int unsigned valid_offset(input int unsigned max_off);
		int unsigned lim;
		lim = (stream_fill < max_off) ? stream_fill : max_off;
		if (lim > 4 && $urandom_range(0, 2) == 0)
			return $urandom_range(1, 4);
		return $urandom_range(1, lim);
	endfunction

	// zero, or past what the frame has filled
	function automatic int unsigned bad_offset(input int unsigned max_off);
		if (stream_fill >= max_off || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(stream_fill + 1, max_off);
	endfunction

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// preamble straight out of reset, then a long preamble under frame start
	task automatic test_preamble();
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7F, 1'b0);
		// two byte literal with the data extremes
		send_byte({6'd1, ELEM_LIT}, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		repeat (4) send_byte({1'b1, 7'($urandom_range(0, 127))}, 1'b0);
		send_byte(8'h00, 1'b0);
		stream_fill = 0;
	endtask

	// longest direct length and every extended length code
	task automatic test_literals();
		put_literal(60, 0);
		put_literal(5, 60);
		put_literal(3, 61);
		put_literal(2, 62);
		put_literal(1, 63);
	endtask

	task automatic test_copies();
		put_short_copy(4, 1);
		put_short_copy(11, (stream_fill < 2047) ? stream_fill : 2047);
		put_long_copy(1, 2);
		put_long_copy(64, 1);
		put_long_copy(64, 3);
		put_long_copy(64, stream_fill);
	endtask

	task automatic test_format_errors();
		put_bad_type(6'h3F);
		put_bad_type(6'h00);
		put_short_copy(4, 0);
		put_long_copy(64, 0);
		put_long_copy(5, 16'hFFFF);
		put_short_copy(7, 2047);
		// parsing carries on after errors
		put_literal(2, 0);
		put_short_copy(5, 2);
	endtask

	// frame start landing in the middle of elements
	task automatic test_frame_restart();
		send_byte({6'd9, ELEM_LONG}, 1'b0);
		send_byte(8'h01, 1'b0);
		put_frame_start();
		put_literal(3, 0);
		send_byte({6'd62, ELEM_LIT}, 1'b0);
		send_byte(8'h05, 1'b0);
		put_frame_start();
		put_literal(2, 0);
		// longest literal, 2^32 bytes, dropped after a few
		send_byte({6'd63, ELEM_LIT}, 1'b0);
		repeat (4) send_byte(8'hFF, 1'b0);
		repeat (5) send_byte(8'($urandom_range(0, 255)), 1'b0);
		put_frame_start();
		// frame is empty now, any copy is an error
		put_long_copy(1, 1);
		put_literal(2, 0);
		send_byte({3'd0, 3'd2, ELEM_SHORT}, 1'b0);
		put_frame_start();
		put_literal(4, 0);
	endtask

	// receiver holds off while the sender keeps pushing, so the block backs up
	task automatic test_back_pressure();
		hold_requests++;
		put_literal(12, 0);
		put_long_copy(64, 1);
		put_literal(10, 61);
		put_long_copy(64, valid_offset(65535));
		put_short_copy(11, valid_offset(2047));
	endtask

	// mostly well-formed frames with random content, some noise and breaks
	task automatic test_random_stream();
		int unsigned stop_at;
		int unsigned pick;
		stop_at = bytes_sent + RANDOM_ITEMS;
		put_frame_start();
		while (bytes_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 35 || (pick < 75 && stream_fill == 0)) begin
				put_literal(($urandom_range(0, 5) == 0) ? $urandom_range(9, 60) : $urandom_range(1, 8),
					($urandom_range(0, 3) == 0) ? $urandom_range(60, 63) : 0);
			end else if (pick < 55) begin
				put_short_copy($urandom_range(4, 11), valid_offset(2047));
			end else if (pick < 75) begin
				put_long_copy(($urandom_range(0, 3) == 0) ? $urandom_range(33, 64) : $urandom_range(1, 32),
					valid_offset(65535));
			end else if (pick < 80) begin
				put_bad_type(6'($urandom_range(0, 63)));
			end else if (pick < 84) begin
				put_short_copy($urandom_range(4, 11), bad_offset(2047));
			end else if (pick < 88) begin
				put_long_copy($urandom_range(1, 64), bad_offset(65535));
			end else if (pick < 93) begin
				put_frame_start();
			end else begin
				// a broken element of random bytes, resynced by a new frame
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
				put_frame_start();
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_preamble();
		test_literals();
		test_copies();
		test_format_errors();
		test_frame_restart();
		test_back_pressure();
		test_random_stream();

		in_valid <= 1'b0;
		@(posedge clk);
		while (decoded_q.size() != 0)
			@(posedge clk);
		// anything extra the block still emits shows up as a stray result
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
